// File: design/bnwf_pkg.sv
// Shared types and constants for the batch-norm weight folding block.
// No dependencies; every other file of the block but bnwf_if imports this package.
package bnwf_pkg;

    localparam int DATA_WIDTH_DEF  = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int FIELD_W = 32;
    localparam int VAR_W   = 31;
    localparam int EPS_W   = 16;
    localparam int SUM_W   = 32;
    localparam int DIFF_W  = 33;

    localparam logic [EPS_W-1:0] EPS_RESET = 16'd1;

    localparam logic CMD_HEADER = 1'b0;
    localparam logic CMD_WEIGHT = 1'b1;

    // One classified item on its way from the front to the back.
    typedef struct packed {
        logic                     cmd;
        logic signed [FIELD_W-1:0] opa;   // gamma on a header, weight otherwise
        logic signed [FIELD_W-1:0] beta;
        logic signed [DIFF_W-1:0]  diff;  // conv_bias - running_mean
        logic        [SUM_W-1:0]   sum;   // variance + epsilon, never zero
    } t_entry;

endpackage

// File: design/bnwf_if.sv
// Channel interfaces of the batch-norm weight folding block:
// input items, result items and the epsilon write port. Widths are written out and match bnwf_pkg.
interface bnwf_in_if;
    logic                 valid;
    logic                 ready;
    logic                 command;
    logic signed [31:0]   gamma;
    logic signed [31:0]   beta;
    logic signed [31:0]   running_mean;
    logic        [30:0]   running_variance;
    logic signed [31:0]   conv_bias;
    logic signed [31:0]   weight_value;

    modport source (output valid, command, gamma, beta, running_mean, running_variance,
                    conv_bias, weight_value, input ready);
    modport sink   (input valid, command, gamma, beta, running_mean, running_variance,
                    conv_bias, weight_value, output ready);
endinterface

interface bnwf_out_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic signed [31:0] value;
    logic               saturated;

    modport source (output valid, kind, value, saturated, input ready);
    modport sink   (input valid, kind, value, saturated, output ready);
endinterface

interface bnwf_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] epsilon;

    modport source (output valid, epsilon, input ready);
    modport sink   (input valid, epsilon, output ready);
endinterface

// File: design/batchnorm_weight_fold.sv
// Top level of the batch-norm weight folding block: front, queue and back.
// Depends on bnwf_pkg, bnwf_if, bnwf_front, bnwf_queue and bnwf_back.
//
//   port    | dir | carries
//   --------+-----+---------------------------------------------------
//   i_in    | in  | command, BN header fields or one filter weight
//   i_cfg   | in  | epsilon (Q0.16), always ready
//   o_out   | out | kind, fused bias or weight, saturated flag
//
// A weight item passes the multiply, then the shift/clip into the output
// register. A header first runs the one-bit-per-cycle root and divide loops,
// then the scale clip, the multiply and the shift, bias add and clip.
// The queue keeps accepting, until it is full, while the back end works or the output stalls.
// Reset empties the queue, clears the output valid flag and sets the channel scale to zero.
module batchnorm_weight_fold #(
    parameter int DATA_WIDTH = bnwf_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = bnwf_pkg::FRAC_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bnwf_in_if.sink    i_in,
    bnwf_cfg_if.sink   i_cfg,
    bnwf_out_if.source o_out
);
    import bnwf_pkg::*;

    logic   q_push;
    logic   q_pop;
    logic   q_valid;
    logic   q_full;
    t_entry q_in_entry;
    t_entry q_out_entry;

    bnwf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cfg    (i_cfg),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_entry  (q_in_entry)
    );

    bnwf_queue #(
        .DEPTH (QUEUE_DEPTH_DEF)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in_entry),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_entry (q_out_entry)
    );

    bnwf_back #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_entry (q_out_entry),
        .o_pop     (q_pop),
        .o_out     (o_out)
    );

endmodule

// File: design/bnwf_front.sv
// Front end: holds epsilon, accepts items and classifies them into queue entries.
// Depends on bnwf_pkg and bnwf_if.
module bnwf_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    bnwf_in_if.sink           i_in,
    bnwf_cfg_if.sink          i_cfg,
    input  logic              i_q_full,
    output logic              o_push,
    output bnwf_pkg::t_entry  o_entry
);
    import bnwf_pkg::*;

    logic [EPS_W-1:0] r_eps;
    logic [SUM_W-1:0] sum_raw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= EPS_RESET;
        end else if (i_cfg.valid) begin
            r_eps <= i_cfg.epsilon;
        end
    end

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !i_q_full;
    assign o_push      = i_in.valid && !i_q_full;

    assign sum_raw = {1'b0, i_in.running_variance} + SUM_W'(r_eps);

    always_comb begin
        o_entry.cmd  = i_in.command;
        o_entry.beta = i_in.beta;
        o_entry.diff = DIFF_W'(i_in.conv_bias) - DIFF_W'(i_in.running_mean);
        // zero variance with zero epsilon counts as one LSB
        o_entry.sum  = (sum_raw == '0) ? SUM_W'(1) : sum_raw;
        unique case (i_in.command)
            CMD_HEADER: o_entry.opa = i_in.gamma;
            CMD_WEIGHT: o_entry.opa = i_in.weight_value;
            default:    o_entry.opa = i_in.weight_value;
        endcase
    end

endmodule

// File: design/bnwf_queue.sv
// Short FIFO of classified items between front and back.
// Depends on bnwf_pkg for the entry type.
module bnwf_queue #(
    parameter int DEPTH = bnwf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  bnwf_pkg::t_entry  i_entry,
    input  logic              i_pop,
    output logic              o_valid,
    output logic              o_full,
    output bnwf_pkg::t_entry  o_entry
);
    import bnwf_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_next(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_next(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_entry = r_mem[r_rd_ptr];

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("queue pushed while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("queue popped while empty");
`endif

endmodule

// File: design/bnwf_back.sv
// Back end: square root, divide and clip for the channel scale, then the
// multiply, shift, bias add and clip for each result; owns the output register.
// Depends on bnwf_pkg and bnwf_if.
module bnwf_back #(
    parameter int DATA_WIDTH = bnwf_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = bnwf_pkg::FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  bnwf_pkg::t_entry  i_q_entry,
    output logic              o_pop,
    bnwf_out_if.source        o_out
);
    import bnwf_pkg::*;

    localparam int VAL_W  = (DATA_WIDTH > FIELD_W) ? FIELD_W : DATA_WIDTH;
    localparam int N_W    = SUM_W + FRAC_BITS;
    localparam int ROOT_W = (N_W + 1) / 2;
    localparam int SQ_W   = 2 * ROOT_W;
    localparam int DIVD_W = FIELD_W + FRAC_BITS;
    localparam int CNT_W  = $clog2(DIVD_W);
    localparam int PROD_W = DIFF_W + FIELD_W;
    localparam int ACC_W  = PROD_W + 1;

    localparam logic [DIVD_W-1:0] SCALE_HI  = (DIVD_W'(1) << (VAL_W - 1)) - DIVD_W'(1);
    localparam logic [DIVD_W-1:0] SCALE_LOM = DIVD_W'(1) << (VAL_W - 1);
    localparam logic signed [ACC_W-1:0] VAL_HI = (ACC_W'(1) << (VAL_W - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] VAL_LO = -VAL_HI - ACC_W'(1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SQRT  = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_SCALE = 3'd3;
    localparam logic [2:0] ST_MUL   = 3'd4;
    localparam logic [2:0] ST_FIN   = 3'd5;

    // control
    logic [2:0]                r_state, n_state;
    logic [CNT_W-1:0]          r_cnt, n_cnt;
    logic                      r_out_valid, n_out_valid;
    logic signed [FIELD_W-1:0] r_scale, n_scale;
    logic                      r_scale_sat, n_scale_sat;
    // payload
    logic                      r_cmd, n_cmd;
    logic signed [DIFF_W-1:0]  r_opa, n_opa;
    logic signed [FIELD_W-1:0] r_gamma, n_gamma;
    logic signed [FIELD_W-1:0] r_beta, n_beta;
    logic [SQ_W-1:0]           r_sq_n, n_sq_n;
    logic [ROOT_W+1:0]         r_sq_rem, n_sq_rem;
    logic [ROOT_W-1:0]         r_sq_root, n_sq_root;
    logic [DIVD_W-1:0]         r_div_d, n_div_d;
    logic [ROOT_W:0]           r_div_rem, n_div_rem;
    logic signed [PROD_W-1:0]  r_prod, n_prod;
    logic                      r_out_kind, n_out_kind;
    logic signed [FIELD_W-1:0] r_out_value, n_out_value;
    logic                      r_out_sat, n_out_sat;

    logic                      out_free;
    logic [ROOT_W+1:0]         sq_shift, sq_trial;
    logic                      sq_ge;
    logic [ROOT_W:0]           dv_shift;
    logic                      dv_ge;
    logic [FIELD_W-1:0]        gamma_mag;
    logic signed [PROD_W-1:0]  prod_sh;
    logic signed [ACC_W-1:0]   acc;
    logic                      acc_hi, acc_lo;

    // one root bit per cycle
    always_comb begin
        sq_shift = {r_sq_rem[ROOT_W-1:0], r_sq_n[SQ_W-1 -: 2]};
        sq_trial = {r_sq_root, 2'b01};
        sq_ge    = (sq_shift >= sq_trial);
    end

    // one quotient bit per cycle, quotient shifts in behind the dividend
    always_comb begin
        dv_shift = {r_div_rem[ROOT_W-1:0], r_div_d[DIVD_W-1]};
        dv_ge    = (dv_shift >= {1'b0, r_sq_root});
    end

    assign gamma_mag = r_gamma[FIELD_W-1] ? FIELD_W'(-r_gamma) : FIELD_W'(r_gamma);

    always_comb begin
        prod_sh = r_prod >>> FRAC_BITS;
        acc     = {prod_sh[PROD_W-1], prod_sh}
                + ((r_cmd == CMD_HEADER) ? ACC_W'(r_beta) : ACC_W'(0));
        acc_hi  = (acc > VAL_HI);
        acc_lo  = (acc < VAL_LO);
    end

    assign out_free = !r_out_valid || o_out.ready;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_scale     = r_scale;
        n_scale_sat = r_scale_sat;
        n_cmd       = r_cmd;
        n_opa       = r_opa;
        n_gamma     = r_gamma;
        n_beta      = r_beta;
        n_sq_n      = r_sq_n;
        n_sq_rem    = r_sq_rem;
        n_sq_root   = r_sq_root;
        n_div_d     = r_div_d;
        n_div_rem   = r_div_rem;
        n_prod      = r_prod;
        n_out_kind  = r_out_kind;
        n_out_value = r_out_value;
        n_out_sat   = r_out_sat;
        o_pop       = 1'b0;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                o_pop = i_q_valid;
            end
            ST_SQRT: begin
                n_sq_n    = r_sq_n << 2;
                n_sq_rem  = sq_ge ? sq_shift - sq_trial : sq_shift;
                n_sq_root = {r_sq_root[ROOT_W-2:0], sq_ge};
                n_cnt     = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    n_div_d   = DIVD_W'(gamma_mag) << FRAC_BITS;
                    n_div_rem = '0;
                    n_cnt     = CNT_W'(DIVD_W - 1);
                    n_state   = ST_DIV;
                end
            end
            ST_DIV: begin
                n_div_d   = {r_div_d[DIVD_W-2:0], dv_ge};
                n_div_rem = dv_ge ? dv_shift - {1'b0, r_sq_root} : dv_shift;
                n_cnt     = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    n_state = ST_SCALE;
                end
            end
            ST_SCALE: begin
                // r_div_d now holds the quotient magnitude
                if (r_gamma[FIELD_W-1]) begin
                    n_scale_sat = (r_div_d > SCALE_LOM);
                    n_scale     = n_scale_sat ? FIELD_W'(VAL_LO)
                                              : FIELD_W'(-r_div_d[FIELD_W-1:0]);
                end else begin
                    n_scale_sat = (r_div_d > SCALE_HI);
                    n_scale     = n_scale_sat ? FIELD_W'(VAL_HI)
                                              : r_div_d[FIELD_W-1:0];
                end
                n_state = ST_MUL;
            end
            ST_MUL: begin
                n_prod  = r_opa * $signed({{(DIFF_W - FIELD_W){r_scale[FIELD_W-1]}}, r_scale});
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = r_cmd;
                    n_out_value = acc_hi ? FIELD_W'(VAL_HI)
                                : acc_lo ? FIELD_W'(VAL_LO)
                                : acc[FIELD_W-1:0];
                    n_out_sat   = acc_hi || acc_lo
                                || ((r_cmd == CMD_HEADER) && r_scale_sat);
                    n_state     = ST_IDLE;
                    o_pop       = i_q_valid;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (o_pop) begin
            n_cmd     = i_q_entry.cmd;
            n_beta    = i_q_entry.beta;
            n_gamma   = i_q_entry.opa;
            n_sq_n    = SQ_W'(i_q_entry.sum) << FRAC_BITS;
            n_sq_rem  = '0;
            n_sq_root = '0;
            n_cnt     = CNT_W'(ROOT_W - 1);
            if (i_q_entry.cmd == CMD_HEADER) begin
                n_opa   = i_q_entry.diff;
                n_state = ST_SQRT;
            end else begin
                n_opa   = DIFF_W'(i_q_entry.opa);
                n_state = ST_MUL;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_scale     <= '0;
            r_scale_sat <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            r_scale     <= n_scale;
            r_scale_sat <= n_scale_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_opa       <= n_opa;
        r_gamma     <= n_gamma;
        r_beta      <= n_beta;
        r_sq_n      <= n_sq_n;
        r_sq_rem    <= n_sq_rem;
        r_sq_root   <= n_sq_root;
        r_div_d     <= n_div_d;
        r_div_rem   <= n_div_rem;
        r_prod      <= n_prod;
        r_out_kind  <= n_out_kind;
        r_out_value <= n_out_value;
        r_out_sat   <= n_out_sat;
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.kind      = r_out_kind;
    assign o_out.value     = r_out_value;
    assign o_out.saturated = r_out_sat;

`ifndef SYNTHESIS
    a_pop_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> i_q_valid && (r_state == ST_IDLE || r_state == ST_FIN))
        else $error("queue popped outside idle or finish");
    a_mul_to_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL) |=> (r_state == ST_FIN))
        else $error("multiply not followed by finish");
    a_root_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_sq_root != '0))
        else $error("divide started with zero root");
`endif

endmodule

// File: test/bnwf_fold_checker.sv
// Result checker for the batch-norm weight folding block: watches the input, epsilon
// and result channels, predicts every result and compares it field by field.
// Depends on bnwf_pkg and the channel interfaces in bnwf_if.
module bnwf_fold_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    bnwf_in_if   i_in,
    bnwf_cfg_if  i_cfg,
    bnwf_out_if  i_out,
    output int   o_errors,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import bnwf_pkg::*;

    localparam longint Q_MAX = (64'sd1 <<< (FIELD_W - 1)) - 1;
    localparam longint Q_MIN = -Q_MAX - 1;
    localparam int     LOG_CAP = 200;

    typedef struct {
        logic               kind;
        logic signed [31:0] value;
        logic               sat;
    } t_fused;

    t_fused             fused_q[$];
    logic [EPS_W-1:0]   eps_reg;
    longint             scale_reg;
    int                 err_cnt = 0;

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        // keep the log short when everything goes wrong
        if (err_cnt < LOG_CAP)
            $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        err_cnt++;
    endtask

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned res, bit_v, rem;
        res   = 0;
        rem   = n;
        bit_v = 64'd1 << 62;
        while (bit_v > rem)
            bit_v >>= 2;
        while (bit_v != 0) begin
            if (rem >= res + bit_v) begin
                rem -= res + bit_v;
                res  = (res >> 1) + bit_v;
            end else begin
                res >>= 1;
            end
            bit_v >>= 2;
        end
        return res;
    endfunction

    function automatic longint clip32(input longint x, inout logic hit);
        if (x > Q_MAX) begin
            hit = 1'b1;
            return Q_MAX;
        end
        if (x < Q_MIN) begin
            hit = 1'b1;
            return Q_MIN;
        end
        return x;
    endfunction

    // Predicts the result of one item; updates the kept channel scale on a header.
    function automatic t_fused fold_item(input logic cmd,
                                         input logic signed [31:0] gam, bet, mean,
                                         input logic [30:0] variance,
                                         input logic signed [31:0] cbias, wval);
        t_fused          r;
        logic            hit;
        longint unsigned sum, root, mag, quo;
        longint          sc, prod;
        hit = 1'b0;
        if (cmd == CMD_HEADER) begin
            sum = 64'(variance) + 64'(eps_reg);
            if (sum == 0)
                sum = 1;
            root = int_sqrt(sum << FRAC_BITS_DEF);
            if (root == 0)
                root = 1;
            sc  = longint'(gam);
            mag = (sc < 0) ? -sc : sc;
            quo = (mag << FRAC_BITS_DEF) / root;
            sc  = (gam < 0) ? -longint'(quo) : longint'(quo);
            scale_reg = clip32(sc, hit);
            prod = (longint'(cbias) - longint'(mean)) * scale_reg;
            sc   = (prod >>> FRAC_BITS_DEF) + longint'(bet);
            r.value = 32'(clip32(sc, hit));
        end else begin
            prod    = longint'(wval) * scale_reg;
            r.value = 32'(clip32(prod >>> FRAC_BITS_DEF, hit));
        end
        r.kind = cmd;
        r.sat  = hit;
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_fused want;
        if (!i_rst_n) begin
            eps_reg   = EPS_RESET;
            scale_reg = 0;
            fused_q.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready)
                eps_reg = i_cfg.epsilon;
            // results are registered, so check before taking this edge's item
            if (i_out.valid && i_out.ready) begin
                if (fused_q.size() == 0) begin
                    flag_mismatch("unexpected result value", i_out.value, 0);
                end else begin
                    want = fused_q.pop_front();
                    if (i_out.kind !== want.kind)
                        flag_mismatch("kind", i_out.kind, want.kind);
                    if (i_out.value !== want.value)
                        flag_mismatch("value", i_out.value, want.value);
                    if (i_out.saturated !== want.sat)
                        flag_mismatch("saturated", i_out.saturated, want.sat);
                end
            end
            if (i_in.valid && i_in.ready)
                fused_q.insert(fused_q.size(),
                               fold_item(i_in.command, i_in.gamma, i_in.beta,
                                         i_in.running_mean, i_in.running_variance,
                                         i_in.conv_bias, i_in.weight_value));
        end
        o_errors  <= err_cnt;
        o_pending <= fused_q.size();
    end

endmodule

// File: test/batchnorm_weight_fold_test.sv
// Top of the batch-norm weight folding testbench: clock, reset, stimulus, result
// stalls and the verdict. Depends on bnwf_pkg, bnwf_if, the block and bnwf_fold_checker.
module batchnorm_weight_fold_test;
    timeunit 1ns;
    timeprecision 1ps;
    import bnwf_pkg::*;

    typedef struct {
        logic               cmd;
        logic signed [31:0] gamma;
        logic signed [31:0] beta;
        logic signed [31:0] mean;
        logic        [30:0] variance;
        logic signed [31:0] bias;
        logic signed [31:0] weight;
    } t_bn_item;

    typedef enum int {RX_OPEN, RX_HALF, RX_SPARSE, RX_MOSTLY} t_rx_mode;

    logic i_clk;
    logic i_rst_n;
    logic long_hold;
    int   fail_cnt;
    int   pending;

    bnwf_in_if  in_ch ();
    bnwf_cfg_if cfg_ch ();
    bnwf_out_if out_ch ();

    batchnorm_weight_fold DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    bnwf_fold_checker u_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_ch),
        .i_cfg     (cfg_ch),
        .i_out     (out_ch),
        .o_errors  (fail_cnt),
        .o_pending (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic signed [31:0] pick_q();
        case ($urandom_range(0, 9))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2, 3:    return $urandom;
            4, 5, 6: return $urandom_range(0, 1 << 19) - (1 << 18);
            7, 8:    return 32'sh0001_0000 + $urandom_range(0, 1 << 17) - (1 << 16);
            default: return $urandom_range(0, 512) - 256;
        endcase
    endfunction

    function automatic logic [30:0] pick_var();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return 31'($urandom);
            3, 4:    return 31'($urandom_range(0, 1 << 18));
            default: return 31'($urandom_range(0, 1 << 12));
        endcase
    endfunction

    // Unused fields carry random values; the block must ignore them.
    function automatic t_bn_item mk_header(input logic signed [31:0] g, b, m,
                                           input logic [30:0] v,
                                           input logic signed [31:0] cb);
        t_bn_item it;
        it.cmd      = CMD_HEADER;
        it.gamma    = g;
        it.beta     = b;
        it.mean     = m;
        it.variance = v;
        it.bias     = cb;
        it.weight   = $urandom;
        return it;
    endfunction

    function automatic t_bn_item mk_weight(input logic signed [31:0] w);
        t_bn_item it;
        it.cmd      = CMD_WEIGHT;
        it.gamma    = $urandom;
        it.beta     = $urandom;
        it.mean     = $urandom;
        it.variance = 31'($urandom);
        it.bias     = $urandom;
        it.weight   = w;
        return it;
    endfunction

    task automatic offer_item(input t_bn_item it);
        in_ch.valid            <= 1'b1;
        in_ch.command          <= it.cmd;
        in_ch.gamma            <= it.gamma;
        in_ch.beta             <= it.beta;
        in_ch.running_mean     <= it.mean;
        in_ch.running_variance <= it.variance;
        in_ch.conv_bias        <= it.bias;
        in_ch.weight_value     <= it.weight;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
    endtask

    // Stop offering and wait for every outstanding result.
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    task automatic write_epsilon(input logic [15:0] eps);
        drain();
        cfg_ch.valid   <= 1'b1;
        cfg_ch.epsilon <= eps;
        @(posedge i_clk);
        while (!cfg_ch.ready)
            @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Channels of one header and a run of weights, with the odd header cutting a
    // channel short. Items go out in bursts with idle gaps bounded by max_gap.
    task automatic send_random(input int n, input int max_gap, input int hold_at,
                               input int pause_at);
        t_bn_item it;
        int       left_in_chan;
        int       burst_left;
        int       gap;
        left_in_chan = 0;
        burst_left   = 0;
        for (int k = 0; k < n; k++) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap        = $urandom_range(0, max_gap);
                if (gap > 0) begin
                    in_ch.valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            burst_left--;
            if (left_in_chan == 0 || $urandom_range(0, 39) == 0) begin
                it = mk_header(pick_q(), pick_q(), pick_q(), pick_var(), pick_q());
                left_in_chan = $urandom_range(1, 14);
            end else begin
                it = mk_weight(pick_q());
                left_in_chan--;
            end
            offer_item(it);
            if (k == hold_at)
                long_hold <= 1'b1;
            if (k == pause_at)
                drain();
        end
    endtask

    initial begin : result_stall
        t_rx_mode mode;
        int       seg_left;
        int       hold_left;
        bit       held;
        out_ch.ready = 1'b0;
        mode      = RX_OPEN;
        seg_left  = 0;
        hold_left = 0;
        held      = 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold && !held) begin
                held      = 1'b1;
                hold_left = $urandom_range(300, 500);
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                if (seg_left == 0) begin
                    seg_left = $urandom_range(16, 200);
                    mode     = t_rx_mode'($urandom_range(0, 3));
                end
                seg_left--;
                case (mode)
                    RX_OPEN:   out_ch.ready <= 1'b1;
                    RX_HALF:   out_ch.ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: out_ch.ready <= ($urandom_range(0, 3) == 0);
                    default:   out_ch.ready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    initial begin : stimulus
        i_rst_n                = 1'b0;
        long_hold              = 1'b0;
        in_ch.valid            = 1'b0;
        in_ch.command          = CMD_HEADER;
        in_ch.gamma            = '0;
        in_ch.beta             = '0;
        in_ch.running_mean     = '0;
        in_ch.running_variance = '0;
        in_ch.conv_bias        = '0;
        in_ch.weight_value     = '0;
        cfg_ch.valid           = 1'b0;
        cfg_ch.epsilon         = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // weights before any header fold with the reset scale of zero
        offer_item(mk_weight(32'sh7FFF_FFFF));
        offer_item(mk_weight(32'sh8000_0000));
        offer_item(mk_header(32'sh0001_0000, 0, 0, 0, 0));
        offer_item(mk_weight(32'sh7FFF_FFFF));
        offer_item(mk_weight(32'sh8000_0000));
        offer_item(mk_weight(-32'sd1));
        // scale and bias both clip high
        offer_item(mk_header(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 0,
                             32'sh7FFF_FFFF));
        offer_item(mk_weight(32'sh7FFF_FFFF));
        offer_item(mk_weight(32'sh8000_0000));
        offer_item(mk_weight(0));
        offer_item(mk_header(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, '1,
                             32'sh8000_0000));
        offer_item(mk_weight(32'sh7FFF_FFFF));
        offer_item(mk_weight(32'sh8000_0000));
        offer_item(mk_header(0, 32'sh0000_8000, 32'sh0001_0000, 31'h0004_0000, 0));
        offer_item(mk_weight(32'sh1234_5678));
        offer_item(mk_header(-32'sh0001_8000, 32'sh0000_8000, 32'sh0001_0000,
                             31'h0004_0000, -32'sh0002_0000));
        offer_item(mk_weight(32'sh0003_0000));

        // zero epsilon with zero variance takes the sum as one LSB
        write_epsilon(16'd0);
        offer_item(mk_header(32'sh0001_0000, 0, 0, 0, 32'sh0001_0000));
        offer_item(mk_weight(32'sh7FFF_FFFF));
        offer_item(mk_weight(32'sh8000_0000));

        write_epsilon(16'hFFFF);
        offer_item(mk_header(32'sh0001_0000, 32'sh0001_0000, 0, '1, 32'sh0001_0000));
        offer_item(mk_weight(32'sh7FFF_FFFF));

        send_random(380, 4, 120, -1);
        write_epsilon(16'($urandom_range(1, 65535)));
        send_random(380, 8, -1, 200);
        write_epsilon(16'd0);
        send_random(380, 0, -1, -1);
        write_epsilon(16'd1);
        send_random(380, 3, -1, -1);
        write_epsilon(16'($urandom_range(1, 32)));
        send_random(380, 6, -1, -1);

        drain();
        repeat (100) @(posedge i_clk);
        if (fail_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: batchnorm_weight_fold.f
design/bnwf_pkg.sv
design/bnwf_if.sv
design/bnwf_front.sv
design/bnwf_queue.sv
design/bnwf_back.sv
design/batchnorm_weight_fold.sv
test/bnwf_fold_checker.sv
test/batchnorm_weight_fold_test.sv
